/* design/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int WORD_BITS        = 32;
	localparam int LEN_W            = 6;
	localparam int SYM_W            = 8;
	localparam int ENTRY_W          = WORD_BITS + LEN_W;
	localparam int OP_W             = 2;
	localparam int IN_DATA_W        = 48;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_BITS);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic in_range;
	} ctrl_t;

	typedef struct packed {
		logic                 valid;
		logic [WORD_BITS-1:0] word;
		logic                 last;
	} res_t;

endpackage

/* design/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/hcbp_pack.sv */
// ----------------------------------------------------------------------------
// hcbp_pack
// accumulator stage: appends looked-up code bits and emits full or flushed words
// ----------------------------------------------------------------------------
module hcbp_pack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  hcbp_pkg::ctrl_t               ctrl_s1,
	input  logic [hcbp_pkg::WORD_BITS-1:0] code_s1,
	input  logic [hcbp_pkg::LEN_W-1:0]    len_s1,
	output hcbp_pkg::res_t                res
);
	import hcbp_pkg::*;

	logic [WORD_BITS-1:0]   acc_q;
	logic [4:0]             filled_q;
	logic [6:0]             total;
	logic [2*WORD_BITS-1:0] buf_w;
	logic                   do_enc;
	logic                   do_flush;
	logic [WORD_BITS-1:0]   acc_d;
	logic [4:0]             filled_d;

	assign total = 7'(filled_q) + 7'(len_s1);
	assign buf_w = {acc_q, {WORD_BITS{1'b0}}} | ((2*WORD_BITS)'(code_s1) << (7'd64 - total));

	always_comb begin
		do_enc   = 1'b0;
		do_flush = 1'b0;
		acc_d    = acc_q;
		filled_d = filled_q;
		res      = '0;
		if (ctrl_s1.valid) begin
			case (ctrl_s1.op)
				OP_ENCODE: begin
					do_enc = ctrl_s1.in_range && (len_s1 != '0) && (len_s1 <= MAX_LEN);
				end
				OP_FLUSH: begin
					do_flush = (filled_q != '0);
				end
				default: begin
				end
			endcase
		end
		if (do_enc) begin
			filled_d = total[4:0];
			if (total[5]) begin
				acc_d     = buf_w[WORD_BITS-1:0];
				res.valid = 1'b1;
				res.word  = buf_w[2*WORD_BITS-1:WORD_BITS];
			end else begin
				acc_d = buf_w[2*WORD_BITS-1:WORD_BITS];
			end
		end
		if (do_flush) begin
			acc_d     = '0;
			filled_d  = '0;
			res.valid = 1'b1;
			res.word  = acc_q;
			res.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			filled_q <= '0;
		end else if (adv) begin
			acc_q    <= acc_d;
			filled_q <= filled_d;
		end
	end

endmodule

/* design/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// code table in ram, bit accumulator and registered output stream
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output is not stalled. A load
// writes the code table ram in the cycle it is accepted; an encode reads the
// table at the same edge, the entry and request control are registered in
// stage 1, and from there the looked-up code is merged into the 32-bit
// accumulator and a completed word is registered on the output. The table
// ram has one write port for loads and one read port for encodes. An encode
// right after a load of the same symbol sees the new entry. A stalled output
// holds the pipeline and drops s_tready in the same cycle.
module huffman_code_bit_packer #(
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// symbol, code_bits, code_length, zero pad
	input  logic [hcbp_pkg::IN_DATA_W-1:0] s_tdata,
	// op
	input  logic [hcbp_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// packed_word
	output logic [hcbp_pkg::WORD_BITS-1:0] m_tdata,
	// is_final
	output logic                           m_tlast
);
	import hcbp_pkg::*;

	localparam int AW = $clog2(SYMBOL_COUNT);

	logic                 adv;
	logic                 accept;
	op_t                  op_in;
	logic [SYM_W-1:0]     sym_in;
	logic [WORD_BITS-1:0] code_in;
	logic [LEN_W-1:0]     len_in;
	logic [LEN_W-1:0]     len_clamp;
	logic [WORD_BITS-1:0] code_mask;
	logic                 in_range;
	logic                 we;
	logic                 re;
	logic [ENTRY_W-1:0]   wdata;
	logic [ENTRY_W-1:0]   rdata;
	ctrl_t                ctrl_s1;
	res_t                 res;
	res_t                 out_q;

	assign op_in   = op_t'(s_tuser);
	assign sym_in  = s_tdata[SYM_W-1:0];
	assign code_in = s_tdata[SYM_W+WORD_BITS-1:SYM_W];
	assign len_in  = s_tdata[SYM_W+WORD_BITS+LEN_W-1:SYM_W+WORD_BITS];

	assign adv      = !out_q.valid || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	assign in_range  = {1'b0, sym_in} < 9'(SYMBOL_COUNT);
	assign len_clamp = (len_in > MAX_LEN) ? MAX_LEN : len_in;
	assign code_mask = WORD_BITS'(~({(2*WORD_BITS){1'b1}} << len_clamp));
	assign wdata     = {len_clamp, code_in & code_mask};
	assign we        = accept && (op_in == OP_LOAD) && in_range;
	assign re        = accept && (op_in == OP_ENCODE);

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (sym_in[AW-1:0]),
		.wdata (wdata),
		.re    (re),
		.raddr (sym_in[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid    <= s_tvalid;
			ctrl_s1.op       <= op_in;
			ctrl_s1.in_range <= in_range;
		end
	end

	hcbp_pack u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctrl_s1 (ctrl_s1),
		.code_s1 (rdata[WORD_BITS-1:0]),
		.len_s1  (rdata[ENTRY_W-1:WORD_BITS]),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (adv) begin
			out_q.valid <= res.valid;
			if (res.valid) begin
				out_q.word <= res.word;
				out_q.last <= res.last;
			end
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = out_q.word;
	assign m_tlast  = out_q.last;

endmodule

/* design/hcbp_checker.sv */
// ----------------------------------------------------------------------------
// hcbp_checker
// port-level checks of the code bit packer, bound to the top level
// ----------------------------------------------------------------------------
module hcbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [hcbp_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [hcbp_pkg::OP_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hcbp_pkg::WORD_BITS-1:0] m_tdata,
	input logic                           m_tlast
);
	import hcbp_pkg::*;

	logic load_req;

	assign load_req = s_tvalid && s_tready && (s_tuser == OP_LOAD) && (s_tdata[0] || !s_tdata[0]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while stalled");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_load_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		load_req ##1 (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("table load produced an output word");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

/* verif/huffman_code_bit_packer_test.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_test
// self-checking bench for the code bit packer: loads, encodes and flushes
// are sent on the input stream in random bursts while the output stream
// stalls on its own pattern; a scoreboard keeps its own code table and
// accumulator, predicts every packed word and compares it on arrival
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_test;

	import hcbp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 900;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 last;
	} packed_word_t;

	class packer_scoreboard;
		logic [WORD_BITS-1:0] code_mem [SYMBOL_COUNT_DEF];
		logic [LEN_W-1:0]     len_mem [SYMBOL_COUNT_DEF];
		logic [WORD_BITS-1:0] acc_word;
		int unsigned          fill_count;
		packed_word_t         expected_words[$];
		int                   errors;

		function new();
			foreach (code_mem[i]) begin
				code_mem[i] = '0;
				len_mem[i] = '0;
			end
			acc_word = '0;
			fill_count = 0;
			errors = 0;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
				logic [WORD_BITS-1:0] code, logic [LEN_W-1:0] len);
			logic [LEN_W-1:0] stored_len;
			logic [63:0]      merged;
			int unsigned      total;
			packed_word_t     item;
			case (op)
				OP_LOAD: begin
					stored_len = (len > MAX_LEN) ? MAX_LEN : len;
					len_mem[sym] = stored_len;
					if (stored_len == MAX_LEN)
						code_mem[sym] = code;
					else
						code_mem[sym] = code & ((32'h1 << stored_len) - 32'h1);
				end
				OP_ENCODE: begin
					if (len_mem[sym] != 0) begin
						total = fill_count + len_mem[sym];
						merged = {acc_word, 32'h0} | ({32'h0, code_mem[sym]} << (64 - total));
						if (total >= WORD_BITS) begin
							item.word = merged[63:32];
							item.last = 1'b0;
							expected_words.push_back(item);
							acc_word = merged[31:0];
							fill_count = total - WORD_BITS;
						end else begin
							acc_word = merged[63:32];
							fill_count = total;
						end
					end
				end
				OP_FLUSH: begin
					if (fill_count != 0) begin
						item.word = acc_word;
						item.last = 1'b1;
						expected_words.push_back(item);
						acc_word = '0;
						fill_count = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(logic [WORD_BITS-1:0] word, logic last);
			packed_word_t item;
			if (expected_words.size() == 0) begin
				$error("unexpected packed_word %h is_final %b", word, last);
				errors++;
			end else begin
				item = expected_words.pop_front();
				if (word !== item.word) begin
					$error("packed_word mismatch: expected %h, got %h", item.word, word);
					errors++;
				end
				if (last !== item.last) begin
					$error("is_final mismatch: expected %b, got %b", item.last, last);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// symbol, code_bits, code_length, zero pad
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// op
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// packed_word
	logic [WORD_BITS-1:0] m_tdata;
	// is_final
	logic                 m_tlast;

	packer_scoreboard board = new();

	bit   loaded[SYMBOL_COUNT_DEF];
	logic [SYM_W-1:0] loaded_syms[$];
	int   burst_left = 0;
	bit   hold_req = 0;
	int   hold_left = 0;
	int   ready_mode = 0;
	int   cycle_count = 0;
	int   idle_cycles = 0;

	huffman_code_bit_packer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [WORD_BITS-1:0] code, input logic [LEN_W-1:0] len);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, len, code, sym};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, sym, code, len);
		if (op == OP_LOAD && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
		end
	endtask

	task automatic wait_all_words();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// receiver: stall pattern, long hold-off on request, result checking
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (m_tvalid && m_tready)
				board.check_word(m_tdata, m_tlast);
			if (cycle_count % 64 == 0)
				ready_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				case (ready_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= (cycle_count % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int count;
		int pick;
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of length, stray and overlong codes, empty flush
		send_request(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
		send_request(OP_LOAD, 8'd255, 32'h0000_0001, 6'd1);
		send_request(OP_LOAD, 8'd1, 32'hDEAD_BEEF, 6'd0);
		send_request(OP_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd5);
		send_request(OP_LOAD, 8'd3, 32'hA5A5_5A5A, 6'd63);
		send_request(OP_LOAD, 8'd4, 32'h0000_0000, 6'd31);
		send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd0, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd1, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd255, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd3, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
		send_request(OP_FLUSH, 8'd0, 32'hFFFF_FFFF, 6'd63);
		send_request(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd255, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
		send_request(OP_UNUSED, 8'd0, 32'hFFFF_FFFF, 6'd32);
		send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		send_request(OP_LOAD, 8'd0, 32'h0000_0000, 6'd32);
		send_request(OP_ENCODE, 8'd0, 32'h0, 6'd0);
		send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
		send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);

		// random: loads mixed with mostly encodes, flushes and a few stray ops
		count = 0;
		while (count < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_request(OP_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
					LEN_W'($urandom_range(0, 63)));
				continue;
			end
			if (pick < 17 || loaded_syms.size() < 4) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = 6'd0;
				else if (pick < 12)
					len = 6'd32;
				else if (pick < 16)
					len = LEN_W'($urandom_range(33, 63));
				else if (pick < 22)
					len = 6'd31;
				else
					len = LEN_W'($urandom_range(1, 16));
				send_request(OP_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, len);
			end else if (pick < 25) begin
				send_request(OP_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
					LEN_W'($urandom_range(0, 63)));
			end else begin
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				send_request(OP_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
			end
			count++;
			if (count == 300)
				hold_req = 1;
			if (count == 600)
				wait_all_words();
		end

		wait_all_words();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
